### rtl/mwg_pkg.sv
// package for the multi waveform generator: widths, codes and the quarter-wave sine table
package mwg_pkg;

  // fixed sizes
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SAMPLE_BITS      = 16;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SUM_W            = (SAMPLE_BITS + 1 > 20) ? SAMPLE_BITS + 1 : 20;

  // configuration register indexes
  localparam logic [1:0] CFG_WAVE_TYPE  = 2'd0;
  localparam logic [1:0] CFG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] CFG_PHASE_STEP = 2'd2;

  // waveform codes
  localparam logic [2:0] WAVE_NOISE    = 3'd0;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd1;
  localparam logic [2:0] WAVE_SINE     = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd4;

  // register reset values
  localparam logic [2:0]         WAVE_TYPE_RST  = WAVE_SAWTOOTH;
  localparam logic signed [15:0] AMPLITUDE_RST  = 16'sd16384;
  localparam logic [31:0]        PHASE_STEP_RST = 32'd42852281;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] sine_lut_t [SINE_TABLE_DEPTH+1];

  // quarter-wave table, integer Taylor series up to x^15, evaluated at elaboration
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t          lut;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      lut[k] = v[14:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

### rtl/multi_waveform_generator.sv
// multi waveform tone generator: phase accumulator, waveform shaping, mix and saturation
// an accepted word moves through the input stage register, then the result register
// throughput: one word per cycle without output stall; the phase add sits in the input
//   stage, the table lookup and the single amplitude multiplier sit in the result stage
// reset: phase and cycle parity clear, both pipeline stages empty, registers take
//   their defaults (sawtooth, amplitude 0.5, step 42852281)
module multi_waveform_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] mix_in, [31:16] random_word
  input  logic        s_axis_tuser,   // [0] restart
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] sample_out
);

  localparam int IDX_W = mwg_pkg::IDX_W;
  localparam int SUM_W = mwg_pkg::SUM_W;
  localparam logic signed [SUM_W-1:0] SAT_MAX =
      SUM_W'((64'sd1 <<< (mwg_pkg::SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_MIN =
      SUM_W'(-(64'sd1 <<< (mwg_pkg::SAMPLE_BITS - 1)));

  // configuration registers
  logic [2:0]         wave_type_q;
  logic signed [15:0] amplitude_q;
  logic [31:0]        phase_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_type_q  <= mwg_pkg::WAVE_TYPE_RST;
      amplitude_q  <= mwg_pkg::AMPLITUDE_RST;
      phase_step_q <= mwg_pkg::PHASE_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mwg_pkg::CFG_WAVE_TYPE:  wave_type_q  <= cfg_data_i[2:0];
        mwg_pkg::CFG_AMPLITUDE:  amplitude_q  <= $signed(cfg_data_i[15:0]);
        mwg_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q;
  logic s2_valid_q;
  logic s2_adv;
  logic s1_adv;
  logic in_acc;

  assign s2_adv        = !s2_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && s2_adv;
  assign s_axis_tready = !s1_valid_q || s2_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // phase accumulator, restart applies before this word's sample
  logic [31:0] phase_q;
  logic        parity_q;
  logic [31:0] phase_use;
  logic        parity_use;
  logic [32:0] phase_sum;

  assign phase_use  = s_axis_tuser ? 32'd0 : phase_q;
  assign parity_use = s_axis_tuser ? 1'b0 : parity_q;
  assign phase_sum  = {1'b0, phase_use} + {1'b0, phase_step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 32'd0;
      parity_q <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_sum[31:0];
      parity_q <= parity_use ^ phase_sum[32];
    end
  end

  // sine table index with quadrant mirroring
  logic [29+IDX_W:0] idx_full;
  logic [IDX_W-1:0]  idx_raw;
  logic [IDX_W-1:0]  idx_d;

  assign idx_full = {{IDX_W{1'b0}}, phase_use[29:0]} *
                    (30 + IDX_W)'(mwg_pkg::SINE_TABLE_DEPTH);
  assign idx_raw  = idx_full[29+IDX_W:30];
  assign idx_d    = phase_use[30] ? IDX_W'(mwg_pkg::SINE_TABLE_DEPTH) - idx_raw : idx_raw;

  // input stage register
  logic signed [15:0] mix_q;
  logic [15:0]        rnd_q;
  logic [15:0]        ramp_q;
  logic               parity_s1_q;
  logic               sine_neg_q;
  logic [IDX_W-1:0]   idx_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mix_q       <= $signed(s_axis_tdata[15:0]);
      rnd_q       <= s_axis_tdata[31:16];
      ramp_q      <= {~phase_use[31], phase_use[30:16]};
      parity_s1_q <= parity_use;
      sine_neg_q  <= phase_use[31];
      idx_q       <= idx_d;
    end
  end

  // multiplier operand select
  logic signed [16:0] sine_val;
  logic signed [16:0] noise_m;
  logic signed [16:0] mul_b;
  logic signed [32:0] prod;

  assign sine_val = sine_neg_q ? -$signed({2'b00, mwg_pkg::SINE_LUT[idx_q]})
                               : $signed({2'b00, mwg_pkg::SINE_LUT[idx_q]});
  assign noise_m  = $signed({rnd_q, 1'b0}) - 17'sd65535;

  always_comb begin
    case (wave_type_q)
      mwg_pkg::WAVE_NOISE: mul_b = noise_m;
      mwg_pkg::WAVE_SINE:  mul_b = sine_val;
      default:             mul_b = {ramp_q[15], ramp_q};
    endcase
  end

  assign prod = 33'(amplitude_q) * 33'(mul_b);

  // q15 product, floor shift
  logic signed [SUM_W-1:0] q15;
  assign q15 = SUM_W'($signed(prod[32:15]));

  // noise: divide magnitude by 65535, truncated toward zero
  logic [31:0]             noise_abs;
  logic [32:0]             noise_acc;
  logic [SUM_W-1:0]        noise_q16;
  logic signed [SUM_W-1:0] noise_res;

  assign noise_abs = prod[32] ? 32'(-prod) : prod[31:0];
  assign noise_acc = {1'b0, noise_abs} + {17'd0, noise_abs[31:16]} + 33'd1;
  assign noise_q16 = SUM_W'(noise_acc[32:16]);
  assign noise_res = prod[32] ? -$signed(noise_q16) : $signed(noise_q16);

  // tone select, mix and saturate
  logic signed [SUM_W-1:0] amp_ext;
  logic signed [SUM_W-1:0] mix_ext;
  logic signed [SUM_W-1:0] sum;
  logic [15:0]             sample_d;
  logic [15:0]             sample_q;

  assign amp_ext = SUM_W'(amplitude_q);
  assign mix_ext = SUM_W'(mix_q);

  always_comb begin
    case (wave_type_q)
      mwg_pkg::WAVE_NOISE:    sum = noise_res;
      mwg_pkg::WAVE_SAWTOOTH: sum = mix_ext + q15;
      mwg_pkg::WAVE_SINE:     sum = mix_ext + q15;
      mwg_pkg::WAVE_SQUARE:   sum = parity_s1_q ? mix_ext - amp_ext : mix_ext + amp_ext;
      mwg_pkg::WAVE_TRIANGLE: sum = parity_s1_q ? mix_ext - q15 : mix_ext + q15;
      default:                sum = mix_ext;
    endcase
    if (sum > SAT_MAX) begin
      sample_d = SAT_MAX[15:0];
    end else if (sum < SAT_MIN) begin
      sample_d = SAT_MIN[15:0];
    end else begin
      sample_d = sum[15:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sample_q <= sample_d;
    end
  end

  assign m_axis_tdata = sample_q;

  // phase advances by the step from the phase in use
  a_phase_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> phase_q == $past(phase_use) + $past(phase_step_q))
    else $error("phase did not advance by the step");

  // phase and parity hold without an accepted word
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(phase_q) && $stable(parity_q))
    else $error("phase changed without an accepted word");

  // a restart leaves parity clear since one step cannot wrap from zero
  a_restart_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> !parity_q)
    else $error("parity set after restart");

  // a result only appears from a filled input stage
  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q))
    else $error("result valid without a word in the input stage");

endmodule

### verif/mwg_checker.sv
`timescale 1ns / 100ps
// checker for the waveform generator: tracks tone state, predicts each sample, compares results
module mwg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_data_i,    // [15:0] mix_in, [31:16] random_word
  input  logic        s_user_i,    // [0] restart
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,    // [15:0] sample_out
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import mwg_pkg::*;

  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (SAMPLE_BITS - 1));

  // quarter-wave sine points, rebuilt here independently of the block
  int                 sine_quarter [SINE_TABLE_DEPTH+1];

  // mirrored registers and tone state
  logic [2:0]         wave_q;
  logic signed [15:0] amp_q;
  logic [31:0]        step_q;
  logic [31:0]        phase_q;
  logic               parity_q;
  logic [32:0]        phase_sum;
  logic [15:0]        want;
  int unsigned        fails;

  logic [15:0]        expected_samples [$];

  // integer taylor series for one table point, q30 angle
  function automatic int taylor_sine(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] mag;
    logic [63:0] v;
    longint      acc;
    x    = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = acc;
    v   = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  // q1.15 product, floor after the shift
  function automatic longint q15_product(longint a, longint b);
    return (a * b) >>> 15;
  endfunction

  // sample for one word from the phase as it stands before the advance
  function automatic logic [15:0] tone_sample(logic [15:0] mix_bits, logic [15:0] rnd,
                                              logic [31:0] ph, logic par);
    longint     mix;
    longint     amp;
    longint     ramp;
    longint     tone;
    longint     idx;
    longint     result;
    logic [1:0] quad;
    mix  = longint'($signed(mix_bits));
    amp  = longint'(amp_q);
    ramp = longint'(ph[31:16]) - 32768;
    case (wave_q)
      WAVE_NOISE: begin
        tone   = 2 * longint'(rnd) - 65535;
        result = (amp * tone) / 65535;
      end
      WAVE_SAWTOOTH: begin
        result = mix + q15_product(amp, ramp);
      end
      WAVE_SINE: begin
        quad = ph[31:30];
        idx  = (longint'(ph[29:0]) * SINE_TABLE_DEPTH) >>> 30;
        if (idx > SINE_TABLE_DEPTH) begin
          idx = SINE_TABLE_DEPTH;
        end
        if (quad[0]) begin
          idx = SINE_TABLE_DEPTH - idx;
        end
        tone = sine_quarter[idx];
        if (quad[1]) begin
          tone = -tone;
        end
        result = mix + q15_product(amp, tone);
      end
      WAVE_SQUARE: begin
        result = mix + (par ? -amp : amp);
      end
      WAVE_TRIANGLE: begin
        tone   = q15_product(amp, ramp);
        result = mix + (par ? -tone : tone);
      end
      default: begin
        result = mix;
      end
    endcase
    if (result > SAT_HI) begin
      result = SAT_HI;
    end else if (result < SAT_LO) begin
      result = SAT_LO;
    end
    return result[15:0];
  endfunction

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      sine_quarter[k] = taylor_sine(k);
    end
  end

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   = WAVE_TYPE_RST;
      amp_q    = AMPLITUDE_RST;
      step_q   = PHASE_STEP_RST;
      phase_q  = '0;
      parity_q = 1'b0;
      fails    = 0;
      expected_samples.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result word against the oldest prediction
      if (m_valid_i && m_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: expected no word, actual %0d", $signed(m_data_i));
          fails++;
        end else begin
          want = expected_samples.pop_front();
          if (m_data_i !== want) begin
            $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(m_data_i));
            fails++;
          end
        end
      end
      // register writes, unknown index ignored
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WAVE_TYPE:  wave_q = cfg_data_i[2:0];
          CFG_AMPLITUDE:  amp_q  = cfg_data_i[15:0];
          CFG_PHASE_STEP: step_q = cfg_data_i;
          default: ;
        endcase
      end
      // input word: restart, predict, then advance phase and parity
      if (s_valid_i && s_ready_i) begin
        if (s_user_i) begin
          phase_q  = '0;
          parity_q = 1'b0;
        end
        expected_samples.push_back(tone_sample(s_data_i[15:0], s_data_i[31:16],
                                               phase_q, parity_q));
        phase_sum = {1'b0, phase_q} + {1'b0, step_q};
        if (phase_sum[32]) begin
          parity_q = ~parity_q;
        end
        phase_q = phase_sum[31:0];
      end
      fail_count_o <= fails;
      pending_o    <= expected_samples.size();
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// testbench top for the waveform generator: clock, reset, stimulus and verdict
module tb;
  import mwg_pkg::*;

  localparam logic [1:0] CFG_SPARE    = 2'd3;
  localparam logic [2:0] WAVE_SPARE   = 3'd7;
  localparam int         RANDOM_WORDS = 400;
  localparam int         CALM_WORDS   = 60;
  localparam int         HOLD_AT      = 100;
  localparam int         HOLD_CYCLES  = 64;
  localparam int         DRAIN_CYCLES = 4;
  localparam int         LIMIT_NS     = 2_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_req     = 1'b0;

  multi_waveform_generator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  mwg_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_valid_i    (s_tvalid),
    .s_ready_i    (s_tready),
    .s_data_i     (s_tdata),
    .s_user_i     (s_tuser),
    .m_valid_i    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_data_i     (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one sample word, maybe after an idle burst with junk on the bus
  task automatic send_word(input logic [15:0] mix, input logic [15:0] rnd,
                           input logic restart);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom();
      s_tuser  <= 1'($urandom());
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rnd, mix};
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
  endtask

  // wait until every predicted sample has come out
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one register write, valid stays high for a following write
  task automatic cfg_write(input logic [1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop the stream, drain, then rewrite all registers; unused bits carry noise
  task automatic apply_settings(input logic [2:0] wave, input logic [15:0] amp,
                                input logic [31:0] step, input bit poke_spare);
    s_tvalid <= 1'b0;
    wait_drained();
    if (poke_spare) begin
      cfg_write(CFG_SPARE, $urandom());
    end
    cfg_write(CFG_WAVE_TYPE, {29'($urandom()), wave});
    cfg_write(CFG_AMPLITUDE, {16'($urandom()), amp});
    cfg_write(CFG_PHASE_STEP, step);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    logic [2:0]  wave;
    logic [15:0] amp;
    logic [15:0] mix;
    logic [31:0] step;
    bit          held;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sawtooth, the most negative mix saturates
    send_word(16'h0000, 16'h0000, 1'b1);
    send_word(16'h7fff, 16'hffff, 1'b0);
    send_word(16'h8000, 16'h0000, 1'b0);
    send_word(16'h5555, 16'haaaa, 1'b1);

    // noise at most negative amplitude, word zero hits the positive limit
    apply_settings(WAVE_NOISE, 16'h8000, 32'hffff_ffff, 1'b1);
    send_word(16'h7fff, 16'h0000, 1'b0);
    send_word(16'h0000, 16'hffff, 1'b0);
    send_word(16'h8000, 16'h7fff, 1'b1);
    send_word(16'h1234, 16'h8000, 1'b0);

    // sine in quarter steps, every quadrant and the mirrored table end
    apply_settings(WAVE_SINE, 16'h7fff, 32'h4000_0000, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b1);
    send_word(16'h7fff, 16'h0000, 1'b0);
    send_word(16'h8000, 16'hffff, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b0);

    // square flips on each wrap
    apply_settings(WAVE_SQUARE, 16'h8000, 32'h8000_0000, 1'b0);
    send_word(16'h7fff, 16'h0000, 1'b1);
    send_word(16'h8000, 16'h0000, 1'b0);
    send_word(16'h7fff, 16'h0000, 1'b0);
    send_word(16'h8000, 16'h0000, 1'b0);

    // triangle with a restart in the middle
    apply_settings(WAVE_TRIANGLE, 16'h7fff, 32'hc000_0000, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b1);
    send_word(16'h7fff, 16'h0000, 1'b0);
    send_word(16'h8000, 16'h0000, 1'b1);
    send_word(16'h0000, 16'h0000, 1'b0);

    // unused wave type passes the mix through
    apply_settings(WAVE_SPARE, 16'h0001, 32'd0, 1'b1);
    send_word(16'h7fff, 16'hffff, 1'b0);
    send_word(16'h8000, 16'h0000, 1'b1);

    // random phases of random settings
    sent = 0;
    held = 1'b0;
    while (sent < RANDOM_WORDS) begin
      src_idle_en  = (sent < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (sent < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
      wave = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 5))
        0:       amp = 16'h8000;
        1:       amp = 16'h7fff;
        2:       amp = 16'h0000;
        default: amp = 16'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       step = 32'd0;
        1:       step = 32'hffff_ffff;
        2:       step = $urandom_range(1, 1 << 20);
        3:       step = PHASE_STEP_RST;
        default: step = $urandom();
      endcase
      apply_settings(wave, amp, step, $urandom_range(0, 3) == 0);
      // long hold-off at the head of a run, so enough words follow to fill the block
      if (!held && sent >= HOLD_AT) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      len = $urandom_range(10, 50);
      for (int i = 0; i < len && sent < RANDOM_WORDS; i++) begin
        // last stretch runs without idling on either side
        if (sent == RANDOM_WORDS - CALM_WORDS) begin
          src_idle_en  = 1'b0;
          sink_idle_en = 1'b0;
        end
        if ($urandom_range(0, 7) == 0) begin
          mix = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        end else begin
          mix = 16'($urandom());
        end
        send_word(mix, 16'($urandom()), $urandom_range(0, 15) == 0);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
